// File: sv/arfs_pkg.sv
// ----------------------------------------------------------------------------
// arfs_pkg - shared types and constants for the repulsion force accumulator
// Item structs for both channels, the sequencer state type and the fixed
// widths of the force sums and the shared divide / square root unit.
// ----------------------------------------------------------------------------
package arfs_pkg;

  localparam int MAX_AGENTS = 32;

  localparam int SUM_W  = 40;
  localparam int CNT_W  = 6;
  localparam int STEP_W = 7;

  localparam logic [CNT_W-1:0]  CNT_MAX       = 6'd63;
  localparam logic [CNT_W-1:0]  AGENTS_RESET  = 6'd2;

  // iteration counts of the shared unit
  localparam logic [STEP_W-1:0] SQRT_STEPS = 7'd32;
  localparam logic [STEP_W-1:0] DIV1_STEPS = 7'd79;
  localparam logic [STEP_W-1:0] DIV2_STEPS = 7'd64;
  localparam logic [STEP_W-1:0] AVG_STEPS  = 7'd40;

  localparam logic [31:0] MAG_NEG_CAP = 32'h8000_0000;
  localparam logic [31:0] MAG_POS_CAP = 32'h7fff_ffff;

  typedef struct packed {
    logic signed [31:0] own_x;
    logic signed [31:0] own_y;
    logic signed [31:0] peer_x;
    logic signed [31:0] peer_y;
    logic               batch_end;
  } req_item_t;

  typedef struct packed {
    logic signed [31:0] peer_force_x;
    logic signed [31:0] peer_force_y;
    logic               coincident;
    logic signed [31:0] total_force_x;
    logic signed [31:0] total_force_y;
    logic               total_valid;
    logic               is_last;
  } rsp_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PREP,
    S_SQX,
    S_SQY,
    S_SUM,
    S_SQRT,
    S_ROOT,
    S_LDD1,
    S_DIV1,
    S_LDD2,
    S_DIV2,
    S_TERM,
    S_ACCUM,
    S_LDA,
    S_AVG,
    S_AVST,
    S_DONE
  } state_t;

endpackage

// File: sv/agent_repulsion_force_sum.sv
// ----------------------------------------------------------------------------
// agent_repulsion_force_sum - inverse-square repulsion force accumulator
// Per neighbour item: offset, squared distance, integer square root and the
// term -d/dist^3 per axis in Q8.24, summed over a round and averaged by the
// agent count on the last item of a complete round.
// ----------------------------------------------------------------------------
//  channel | signals                       | direction | item
//  --------+-------------------------------+-----------+----------------------
//  req     | req_valid, req_stall, req     | in        | positions, batch_end
//  rsp     | rsp_valid, rsp_stall, rsp     | out       | peer and total forces
//  cfg     | cfg_wr_en, cfg_wr_data        | in        | agent_count
//
//  One restoring compare/subtract unit does all the iterative work: 32 square
//  root steps, then per axis 79 steps of offset*2^48/S and 64 steps of /root.
//  A new item is accepted only after the previous result is loaded into rsp; a
//  valid round end also runs the two averages. Coincident neighbours and those
//  with an axis offset of 2^31 or more skip the unit and give zero peer force.
//  req_stall is high from acceptance until the result is loaded into rsp; the
//  rsp register lets the next item start while the previous result waits.
//  rst is synchronous and clears the sums, the count and agent_count to 2.
// ----------------------------------------------------------------------------
module agent_repulsion_force_sum
  import arfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_item_t        req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_item_t        rsp,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  state_t state, state_next;

  logic [CNT_W-1:0]  agent_count;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [CNT_W-1:0]  peer_seen;

  logic signed [32:0] dx, dy;
  logic [30:0]        ax, ay;
  logic               last, coin, axis;
  logic [62:0]        s;
  logic [61:0]        prod;
  logic [31:0]        root;
  logic signed [31:0] fx, fy, tx, ty;
  logic               tvalid;

  // shared unit registers
  logic [78:0]       dvd;
  logic [63:0]       rem, quo, dvs;
  logic              ovf;
  logic [STEP_W-1:0] cnt;

  // control from the sequencer
  logic unit_sqrt, unit_step, rsp_load;

  // ---- shared compare/subtract unit ----
  logic [64:0] rem_sh, trial, diff;
  logic        geq;

  always_comb begin
    if (unit_sqrt) begin
      rem_sh = {rem[62:0], dvd[78:77]};
      trial  = {quo[62:0], 2'b01};
    end else begin
      rem_sh = {rem, dvd[78]};
      trial  = {1'b0, dvs};
    end
    diff = rem_sh - trial;
    geq  = (rem_sh >= trial);
  end

  // ---- shared squarer ----
  logic [30:0] mul_op;
  logic [61:0] mul_res;
  assign mul_op  = (state == S_SQX) ? ax : ay;
  assign mul_res = mul_op * mul_op;

  logic [62:0] s_sum;
  assign s_sum = s + {1'b0, prod};

  // ---- per-axis helpers ----
  logic [31:0]        ax_abs, ay_abs;
  logic               ax_hi, ay_hi;
  logic signed [32:0] d_sel;
  logic [31:0]        term_mag;
  logic [31:0]        term_val;

  always_comb begin
    ax_abs = dx[32] ? 32'(-dx) : dx[31:0];
    ay_abs = dy[32] ? 32'(-dy) : dy[31:0];
    ax_hi  = ax_abs[31];
    ay_hi  = ay_abs[31];
    d_sel  = axis ? dy : dx;
    term_mag = (ovf || (quo[63:31] != '0)) ? MAG_NEG_CAP : quo[31:0];
    // force opposes the offset
    if (!d_sel[32] && (d_sel != '0)) begin
      term_val = 32'(-term_mag);
    end else begin
      term_val = (term_mag > MAG_POS_CAP) ? MAG_POS_CAP : term_mag;
    end
  end

  // ---- saturating sums and count ----
  logic signed [SUM_W:0] sx_wide, sy_wide;
  logic signed [SUM_W-1:0] sx_sat, sy_sat;
  logic [CNT_W-1:0] seen_inc;
  logic             count_ok;

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
    logic signed [SUM_W-1:0] r;
    if (v[SUM_W] != v[SUM_W-1]) begin
      r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    sx_wide  = {sum_x[SUM_W-1], sum_x} + {{(SUM_W-31){fx[31]}}, fx};
    sy_wide  = {sum_y[SUM_W-1], sum_y} + {{(SUM_W-31){fy[31]}}, fy};
    sx_sat   = sat_sum(sx_wide);
    sy_sat   = sat_sum(sy_wide);
    seen_inc = (peer_seen == CNT_MAX) ? peer_seen : peer_seen + 1'b1;
    count_ok = (agent_count >= AGENTS_RESET)
            && ({1'b0, agent_count} <= 7'(MAX_AGENTS))
            && (seen_inc == agent_count - 1'b1);
  end

  // ---- average helpers ----
  logic signed [SUM_W-1:0] avg_src;
  logic [SUM_W-1:0]        avg_mag;
  logic [SUM_W-1:0]        avg_q;
  logic [31:0]             avg_val;

  always_comb begin
    avg_src = axis ? sum_y : sum_x;
    avg_mag = avg_src[SUM_W-1] ? SUM_W'(-avg_src) : avg_src;
    avg_q   = quo[SUM_W-1:0];
    if (avg_src[SUM_W-1]) begin
      avg_val = (avg_q > SUM_W'(MAG_NEG_CAP)) ? MAG_NEG_CAP : 32'(-avg_q[31:0]);
    end else begin
      avg_val = (avg_q > SUM_W'(MAG_POS_CAP)) ? MAG_POS_CAP : avg_q[31:0];
    end
  end

  // ---- sequencer: next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_PREP;
      S_PREP: begin
        if (((ax_abs == '0) && (ay_abs == '0)) || ax_hi || ay_hi) begin
          state_next = S_ACCUM;
        end else begin
          state_next = S_SQX;
        end
      end
      S_SQX:   state_next = S_SQY;
      S_SQY:   state_next = S_SUM;
      S_SUM:   state_next = S_SQRT;
      S_SQRT:  if (cnt == 7'd1) state_next = S_ROOT;
      S_ROOT:  state_next = S_LDD1;
      S_LDD1:  state_next = S_DIV1;
      S_DIV1:  if (cnt == 7'd1) state_next = S_LDD2;
      S_LDD2:  state_next = ovf ? S_TERM : S_DIV2;
      S_DIV2:  if (cnt == 7'd1) state_next = S_TERM;
      S_TERM:  state_next = axis ? S_ACCUM : S_LDD1;
      S_ACCUM: state_next = (last && count_ok) ? S_LDA : S_DONE;
      S_LDA:   state_next = S_AVG;
      S_AVG:   if (cnt == 7'd1) state_next = S_AVST;
      S_AVST:  state_next = axis ? S_DONE : S_LDA;
      S_DONE:  if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ---- sequencer: outputs ----
  always_comb begin
    req_stall = (state != S_IDLE);
    unit_sqrt = (state == S_SQRT);
    unit_step = (state == S_SQRT) || (state == S_DIV1) || (state == S_DIV2)
             || (state == S_AVG);
    rsp_load  = (state == S_DONE) && (!rsp_valid || !rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- control state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      agent_count <= AGENTS_RESET;
      sum_x       <= '0;
      sum_y       <= '0;
      peer_seen   <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) agent_count <= cfg_wr_data;
      if (state == S_ACCUM) begin
        sum_x     <= sx_sat;
        sum_y     <= sy_sat;
        peer_seen <= seen_inc;
      end
      if (rsp_load && last) begin
        sum_x     <= '0;
        sum_y     <= '0;
        peer_seen <= '0;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    if (unit_step) begin
      rem <= geq ? diff[63:0] : rem_sh[63:0];
      quo <= {quo[62:0], geq};
      ovf <= ovf | quo[63];
      dvd <= unit_sqrt ? {dvd[76:0], 2'b00} : {dvd[77:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
    unique case (state)
      S_IDLE: begin
        dx     <= {req.peer_x[31], req.peer_x} - {req.own_x[31], req.own_x};
        dy     <= {req.peer_y[31], req.peer_y} - {req.own_y[31], req.own_y};
        last   <= req.batch_end;
        fx     <= '0;
        fy     <= '0;
        tx     <= '0;
        ty     <= '0;
        tvalid <= 1'b0;
        axis   <= 1'b0;
      end
      S_PREP: begin
        ax   <= ax_abs[30:0];
        ay   <= ay_abs[30:0];
        coin <= (ax_abs == '0) && (ay_abs == '0);
      end
      S_SQX: s    <= {1'b0, mul_res};
      S_SQY: prod <= mul_res;
      S_SUM: begin
        s   <= s_sum;
        dvd <= {1'b0, s_sum, 15'd0};
        rem <= '0;
        quo <= '0;
        ovf <= 1'b0;
        cnt <= SQRT_STEPS;
      end
      S_ROOT: root <= quo[31:0];
      S_LDD1: begin
        dvd <= {(axis ? ay : ax), 48'd0};
        dvs <= {1'b0, s};
        rem <= '0;
        quo <= '0;
        ovf <= 1'b0;
        cnt <= DIV1_STEPS;
      end
      S_LDD2: begin
        dvd <= {quo, 15'd0};
        dvs <= {32'd0, root};
        rem <= '0;
        quo <= '0;
        cnt <= DIV2_STEPS;
      end
      S_TERM: begin
        if (axis) begin
          fy <= term_val;
        end else begin
          fx <= term_val;
        end
        axis <= ~axis;
      end
      S_ACCUM: begin
        tvalid <= last && count_ok;
        axis   <= 1'b0;
      end
      S_LDA: begin
        dvd <= {avg_mag, 39'd0};
        dvs <= {58'd0, agent_count};
        rem <= '0;
        quo <= '0;
        ovf <= 1'b0;
        cnt <= AVG_STEPS;
      end
      S_AVST: begin
        // averaged totals: x after the first pass, y after the second
        if (axis) begin
          ty <= avg_val;
        end else begin
          tx <= avg_val;
        end
        axis <= ~axis;
      end
      S_DONE: begin
        if (rsp_load) begin
          rsp.peer_force_x  <= fx;
          rsp.peer_force_y  <= fy;
          rsp.coincident    <= coin;
          rsp.total_force_x <= tx;
          rsp.total_force_y <= ty;
          rsp.total_valid   <= tvalid;
          rsp.is_last       <= last;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
